@@ hw/rtl/gpb_pkg.sv @@
// Package for the greedy page breaker: word types, widths and item kind codes.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package gpb_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COUNT_BITS  = 16;
    localparam int TARGET_W    = 31;

    // Item kinds
    localparam logic [1:0] KIND_BOX    = 2'd0;
    localparam logic [1:0] KIND_GLUE   = 2'd1;
    localparam logic [1:0] KIND_OTHER  = 2'd2;
    localparam logic [1:0] KIND_ABSENT = 2'd3;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Badness datapath: gaps of five units or more clip, so |gap| fits FRAC_BITS + 3 bits
    localparam int ABS_W       = FRAC_BITS + 3;
    localparam int SQ_W        = 2 * ABS_W;
    localparam int CUBE_W      = 3 * ABS_W;
    localparam int SCALED_W    = CUBE_W + 7;
    localparam int BAD_LSB     = 3 * FRAC_BITS;
    localparam int BAD_RAW_W   = SCALED_W - BAD_LSB;
    localparam int BAD_W       = 14;
    localparam logic [BAD_W-1:0] BAD_MAX = BAD_W'(10000);
    localparam logic [32:0] CLIP_ABS = 33'(5) << FRAC_BITS;

    typedef struct packed {
        logic [1:0]         item_kind;
        logic signed [31:0] box_height;
        logic signed [31:0] box_depth;
        logic signed [31:0] glue_width;
        logic               last_item;
    } t_item;

    typedef struct packed {
        logic signed [31:0] page_height;
        logic [15:0]        page_number;
        logic [15:0]        page_length;
        logic [BAD_W-1:0]   page_badness;
        logic               final_page;
    } t_page;

    // Page record queued by the front; badness still to be worked out from gap
    typedef struct packed {
        logic signed [31:0] height;
        logic [15:0]        number;
        logic [15:0]        length;
        logic signed [32:0] gap;
        logic               final_page;
    } t_page_rec;

    typedef struct packed {
        logic we0;
        logic we1;
    } t_push;

endpackage

`default_nettype wire

@@ hw/rtl/gpb_front.sv @@
// Front of the page breaker: target register, running height, slot and page counts.
// Classifies each word and pushes up to two page records. Depends on gpb_pkg.
`default_nettype none

module gpb_front (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire [gpb_pkg::TARGET_W-1:0]        i_cfg_data,
    input  wire                                i_accept,
    input  wire gpb_pkg::t_item                i_item,
    output gpb_pkg::t_push                     o_push,
    output gpb_pkg::t_page_rec                 o_rec0,
    output gpb_pkg::t_page_rec                 o_rec1
);

    localparam logic [gpb_pkg::COUNT_BITS-1:0] CountMax = '1;

    logic [gpb_pkg::TARGET_W-1:0]   r_target;
    logic signed [31:0]             r_height, n_height;
    logic [gpb_pkg::COUNT_BITS-1:0] r_items, n_items;
    logic [gpb_pkg::COUNT_BITS-1:0] r_pages, n_pages;

    logic signed [32:0] span;
    logic signed [33:0] sum;
    logic               over;
    logic               brk;
    logic               absent;
    logic [gpb_pkg::COUNT_BITS-1:0] items_base;
    gpb_pkg::t_page_rec rec_brk;
    gpb_pkg::t_page_rec rec_fin;

    function automatic logic signed [31:0] sat_span(input logic signed [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat_sum(input logic signed [33:0] v);
        if (!((v[33:31] == 3'b000) || (v[33:31] == 3'b111))) begin
            return v[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return v[31:0];
    endfunction

    always_comb begin
        case (i_item.item_kind)
            gpb_pkg::KIND_BOX:  span = 33'(i_item.box_height) + 33'(i_item.box_depth);
            gpb_pkg::KIND_GLUE: span = 33'(i_item.glue_width);
            default:            span = '0;
        endcase
        absent = (i_item.item_kind == gpb_pkg::KIND_ABSENT);
        sum    = 34'(r_height) + 34'(span);
        over   = sum > $signed({3'b000, r_target});
        brk    = !absent && over && (r_items != '0);

        if (absent) begin
            n_height = r_height;
        end else if (brk) begin
            n_height = sat_span(span);
        end else begin
            n_height = sat_sum(sum);
        end
        items_base = brk ? '0 : r_items;
        n_items    = (items_base == CountMax) ? items_base : items_base + 1'b1;
        n_pages    = brk ? r_pages + 1'b1 : r_pages;

        rec_brk.height     = r_height;
        rec_brk.number     = 16'(r_pages);
        rec_brk.length     = 16'(r_items);
        rec_brk.gap        = $signed({2'b00, r_target}) - 33'(r_height);
        rec_brk.final_page = 1'b0;

        rec_fin.height     = n_height;
        rec_fin.number     = 16'(n_pages);
        rec_fin.length     = 16'(n_items);
        rec_fin.gap        = '0;
        rec_fin.final_page = 1'b1;

        o_push.we0 = i_accept && (brk || i_item.last_item);
        o_push.we1 = i_accept && brk && i_item.last_item;
        o_rec0     = brk ? rec_brk : rec_fin;
        o_rec1     = rec_fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_height <= '0;
            r_items  <= '0;
            r_pages  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_target <= i_cfg_data;
            end
            if (i_accept) begin
                // close the run on the last word
                if (i_item.last_item) begin
                    r_height <= '0;
                    r_items  <= '0;
                    r_pages  <= '0;
                end else begin
                    r_height <= n_height;
                    r_items  <= n_items;
                    r_pages  <= n_pages;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/gpb_queue.sv @@
// Short record queue between front and back; takes up to two records a cycle.
// Depends on gpb_pkg.
`default_nettype none

module gpb_queue (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire gpb_pkg::t_push     i_push,
    input  wire gpb_pkg::t_page_rec i_rec0,
    input  wire gpb_pkg::t_page_rec i_rec1,
    input  wire                   i_pop,
    output gpb_pkg::t_page_rec    o_head,
    output logic                  o_empty,
    output logic                  o_room
);

    gpb_pkg::t_page_rec              r_mem [gpb_pkg::QUEUE_DEPTH];
    logic [gpb_pkg::QPTR_W-1:0]      r_wptr, r_rptr;
    logic [gpb_pkg::QCNT_W-1:0]      r_count, n_count;
    logic [gpb_pkg::QPTR_W-1:0]      wptr1;

    always_comb begin
        wptr1   = r_wptr + 1'b1;
        n_count = r_count + gpb_pkg::QCNT_W'(i_push.we0) + gpb_pkg::QCNT_W'(i_push.we1)
                  - gpb_pkg::QCNT_W'(i_pop);
        o_head  = r_mem[r_rptr];
        o_empty = (r_count == '0);
        // room for a word that closes two pages at once
        o_room  = (r_count <= gpb_pkg::QCNT_W'(gpb_pkg::QUEUE_DEPTH - 2));
    end

    always_ff @(posedge i_clk) begin
        if (i_push.we0) begin
            r_mem[r_wptr] <= i_rec0;
        end
        if (i_push.we1) begin
            r_mem[wptr1] <= i_rec1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + gpb_pkg::QPTR_W'(i_push.we0) + gpb_pkg::QPTR_W'(i_push.we1);
            r_rptr  <= r_rptr + gpb_pkg::QPTR_W'(i_pop);
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= gpb_pkg::QCNT_W'(gpb_pkg::QUEUE_DEPTH))
        else $error("record queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty record queue");

    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.we1 |-> i_push.we0)
        else $error("second lane written without first");

endmodule

`default_nettype wire

@@ hw/rtl/gpb_back.sv @@
// Back of the page breaker: pops a page record, works out the cubic badness in
// three multiply stages and holds the page word in the output register. Depends on gpb_pkg.
`default_nettype none

module gpb_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire gpb_pkg::t_page_rec i_head,
    input  wire                   i_empty,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output gpb_pkg::t_page        o_out_page
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SQ    = 3'd1;
    localparam logic [2:0] ST_CUBE  = 3'd2;
    localparam logic [2:0] ST_SCALE = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]                       r_state, n_state;
    gpb_pkg::t_page_rec               r_rec;
    logic                             r_clip;
    logic [gpb_pkg::ABS_W-1:0]        r_abs;
    logic [gpb_pkg::SQ_W-1:0]         r_sq;
    logic [gpb_pkg::CUBE_W-1:0]       r_cube;
    logic [gpb_pkg::SCALED_W-1:0]     r_scaled;
    logic                             r_out_valid;
    gpb_pkg::t_page                   r_out_page, n_out_page;

    logic [32:0]                      gap_abs;
    logic [gpb_pkg::BAD_RAW_W-1:0]    bad_raw;
    logic [gpb_pkg::BAD_W-1:0]        badness;
    logic                             load;

    always_comb begin
        gap_abs = i_head.gap[32] ? 33'(-i_head.gap) : 33'(i_head.gap);
        bad_raw = r_scaled[gpb_pkg::SCALED_W-1:gpb_pkg::BAD_LSB];
        if (r_rec.final_page) begin
            badness = '0;
        end else if (r_clip || (bad_raw > gpb_pkg::BAD_RAW_W'(gpb_pkg::BAD_MAX))) begin
            badness = gpb_pkg::BAD_MAX;
        end else begin
            badness = gpb_pkg::BAD_W'(bad_raw);
        end

        n_out_page.page_height  = r_rec.height;
        n_out_page.page_number  = r_rec.number;
        n_out_page.page_length  = r_rec.length;
        n_out_page.page_badness = badness;
        n_out_page.final_page   = r_rec.final_page;

        o_pop   = (r_state == ST_IDLE) && !i_empty;
        load    = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (!i_empty) n_state = ST_SQ;
            ST_SQ:    n_state = ST_CUBE;
            ST_CUBE:  n_state = ST_SCALE;
            ST_SCALE: n_state = ST_DONE;
            ST_DONE:  if (load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase

        o_out_valid = r_out_valid;
        o_out_page  = r_out_page;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec  <= i_head;
            r_clip <= (gap_abs >= gpb_pkg::CLIP_ABS);
            r_abs  <= gap_abs[gpb_pkg::ABS_W-1:0];
        end
        if (r_state == ST_SQ) begin
            r_sq <= gpb_pkg::SQ_W'(r_abs) * gpb_pkg::SQ_W'(r_abs);
        end
        if (r_state == ST_CUBE) begin
            r_cube <= gpb_pkg::CUBE_W'(r_sq) * gpb_pkg::CUBE_W'(r_abs);
        end
        if (r_state == ST_SCALE) begin
            r_scaled <= gpb_pkg::SCALED_W'(r_cube) * gpb_pkg::SCALED_W'(100);
        end
        if (load) begin
            r_out_page <= n_out_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_badness_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_page.page_badness <= gpb_pkg::BAD_MAX))
        else $error("badness above limit");

    a_final_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_page.final_page) |-> (r_out_page.page_badness == '0))
        else $error("final page with nonzero badness");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == ST_SQ))
        else $error("pop did not start the badness sequence");

endmodule

`default_nettype wire

@@ hw/rtl/greedy_page_breaker_unit.sv @@
// Top level of the greedy page breaker: front, record queue and badness back end.
// Depends on gpb_pkg, gpb_front, gpb_queue, gpb_back.
//
//   channel | signals                              | direction
//   input   | i_in_valid, o_in_ready, i_in_item    | item words in
//   output  | o_out_valid, i_out_ready, o_out_page | page words out
//   config  | i_cfg_we, i_cfg_data                 | target height write
//
// The front takes one item word per cycle while the record queue has room for two
// records, whether or not the word closes a page.
// Back end steps per page, in order: pop, square, cube, scale by 100, load.
// Reset is synchronous and clears counts, target, queue pointers and output valid.
// A stalled output holds its word; the queue then fills and o_in_ready drops.
`default_nettype none

module greedy_page_breaker_unit (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [gpb_pkg::TARGET_W-1:0]      i_cfg_data,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire gpb_pkg::t_item              i_in_item,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output gpb_pkg::t_page                   o_out_page
);

    gpb_pkg::t_push     push;
    gpb_pkg::t_page_rec rec0, rec1, head;
    logic               q_empty, q_room, pop, accept;

    assign o_in_ready = q_room;
    assign accept     = i_in_valid && q_room;

    gpb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_item     (i_in_item),
        .o_push     (push),
        .o_rec0     (rec0),
        .o_rec1     (rec1)
    );

    gpb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec0  (rec0),
        .i_rec1  (rec1),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_room  (q_room)
    );

    gpb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_page  (o_out_page)
    );

endmodule

`default_nettype wire

@@ tb/gpb_checker.sv @@
`timescale 1ns / 100ps
// Checker for the greedy page breaker: watches the item, page and target ports,
// predicts every page word and compares the outgoing ones in order. Depends on gpb_pkg.
module gpb_checker (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [gpb_pkg::TARGET_W-1:0]  i_cfg_data,
    input  wire                          i_in_valid,
    input  wire                          i_in_ready,
    input  gpb_pkg::t_item               i_in_item,
    input  wire                          i_out_valid,
    input  wire                          i_out_ready,
    input  gpb_pkg::t_page               i_out_page,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_pages_checked
);

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint CLIP_GAP = 64'sd5 <<< gpb_pkg::FRAC_BITS;

    logic [gpb_pkg::TARGET_W-1:0] target_copy;
    longint                       run_height;
    logic [15:0]                  run_slots;
    logic [15:0]                  page_index;
    gpb_pkg::t_page               expected_pages[$];
    int                           mismatch_count = 0;
    int                           words_checked  = 0;

    assign o_fail_count    = mismatch_count;
    assign o_pages_checked = words_checked;

    function automatic logic [gpb_pkg::BAD_W-1:0] cubic_badness(input longint gap);
        longint unsigned mag, sq, hi, lo, x, y, b;
        mag = (gap < 0) ? longint'(-gap) : longint'(gap);
        if (mag >= CLIP_GAP) begin
            return gpb_pkg::BAD_MAX;
        end
        sq = mag * mag;
        hi = sq >> gpb_pkg::FRAC_BITS;
        lo = sq & ((64'd1 << gpb_pkg::FRAC_BITS) - 64'd1);
        x  = 64'd100 * mag * hi;
        y  = (64'd100 * mag * lo) >> gpb_pkg::FRAC_BITS;
        b  = (x + y) >> (2 * gpb_pkg::FRAC_BITS);
        return (b > 64'd10000) ? gpb_pkg::BAD_MAX : gpb_pkg::BAD_W'(b);
    endfunction

    function automatic gpb_pkg::t_page open_page(input logic [gpb_pkg::BAD_W-1:0] badness,
                                                 input logic last_pg);
        gpb_pkg::t_page pg;
        pg.page_height  = run_height[31:0];
        pg.page_number  = page_index;
        pg.page_length  = run_slots;
        pg.page_badness = badness;
        pg.final_page   = last_pg;
        return pg;
    endfunction

    task automatic break_list_item(input gpb_pkg::t_item it);
        longint span;
        longint sum;
        if (it.item_kind != gpb_pkg::KIND_ABSENT) begin
            span = 0;
            if (it.item_kind == gpb_pkg::KIND_BOX) begin
                span = longint'(it.box_height) + longint'(it.box_depth);
            end else if (it.item_kind == gpb_pkg::KIND_GLUE) begin
                span = longint'(it.glue_width);
            end
            // exact compare; only the stored height saturates
            if (run_height + span > longint'(target_copy) && run_slots != 16'd0) begin
                expected_pages.push_back(
                    open_page(cubic_badness(longint'(target_copy) - run_height), 1'b0));
                page_index = page_index + 16'd1;
                run_height = 0;
                run_slots  = 16'd0;
            end
            sum = run_height + span;
            run_height = (sum > S32_MAX) ? S32_MAX : (sum < S32_MIN) ? S32_MIN : sum;
        end
        if (run_slots != 16'hFFFF) begin
            run_slots = run_slots + 16'd1;
        end
        if (it.last_item) begin
            expected_pages.push_back(open_page('0, 1'b1));
            run_height = 0;
            run_slots  = 16'd0;
            page_index = 16'd0;
        end
    endtask

    task automatic check_field(input string name, input longint exp, input longint act);
        if (exp != act) begin
            $display("%0t: page word field %s mismatch, expected %0d, actual %0d",
                     $time, name, exp, act);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        gpb_pkg::t_page exp_pg;
        if (!i_rst_n) begin
            target_copy = '0;
            run_height  = 0;
            run_slots   = 16'd0;
            page_index  = 16'd0;
            expected_pages.delete();
        end else begin
            if (i_cfg_we) begin
                target_copy = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                break_list_item(i_in_item);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_pages.size() == 0) begin
                    $display("%0t: page word with nothing expected, actual height %0d length %0d",
                             $time, i_out_page.page_height, i_out_page.page_length);
                    mismatch_count++;
                end else begin
                    exp_pg = expected_pages.pop_front();
                    words_checked++;
                    check_field("page_height", exp_pg.page_height, i_out_page.page_height);
                    check_field("page_number", exp_pg.page_number, i_out_page.page_number);
                    check_field("page_length", exp_pg.page_length, i_out_page.page_length);
                    check_field("page_badness", exp_pg.page_badness, i_out_page.page_badness);
                    check_field("final_page", exp_pg.final_page, i_out_page.final_page);
                end
            end
        end
        o_pending = expected_pages.size();
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the greedy page breaker testbench: clock, reset, item and target stimulus,
// output back-pressure and the verdict. Depends on gpb_pkg, gpb_checker and the block.
module tb_top;

    localparam int U       = 1 << gpb_pkg::FRAC_BITS;
    localparam int S32_MAX = 32'sh7fffffff;
    localparam int S32_MIN = 32'sh80000000;
    localparam int HOLD_OFF_CYCLES = 300;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         cfg_we;
    logic [gpb_pkg::TARGET_W-1:0] cfg_data;
    logic                         in_valid;
    wire                          in_ready;
    gpb_pkg::t_item               in_item;
    wire                          out_valid;
    logic                         out_ready;
    gpb_pkg::t_page               out_page;

    int  fail_count;
    int  pending;
    int  pages_checked;
    bit  quiet;
    bit  hold_req;
    int  items_sent;
    int  settings_used;

    greedy_page_breaker_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_page  (out_page)
    );

    gpb_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_in_item       (in_item),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_out_page      (out_page),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_pages_checked (pages_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(20, 60);
        end
        return $urandom_range(1, 3);
    endfunction

    // unused fields get random bits so the block has to ignore them
    function automatic gpb_pkg::t_item mk(input logic [1:0] kind, input int a, input int b,
                                          input logic last_it);
        gpb_pkg::t_item it;
        it.item_kind  = kind;
        it.box_height = (kind == gpb_pkg::KIND_BOX) ? a : $urandom;
        it.box_depth  = (kind == gpb_pkg::KIND_BOX) ? b : $urandom;
        it.glue_width = (kind == gpb_pkg::KIND_GLUE) ? a : $urandom;
        it.last_item  = last_it;
        return it;
    endfunction

    function automatic int span_value(input int unsigned step_unit);
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return int'($urandom_range(0, step_unit));
        end else if (r < 65) begin
            return -int'($urandom_range(0, step_unit >> 2));
        end else if (r < 80) begin
            return $urandom;
        end else if (r < 90) begin
            case ($urandom_range(0, 3))
                0: return S32_MIN;
                1: return S32_MAX;
                2: return 0;
                default: return -1;
            endcase
        end
        return int'($urandom_range(0, 6 * U));
    endfunction

    function automatic gpb_pkg::t_item random_item(input int unsigned step_unit,
                                                   input logic last_it);
        int         r;
        logic [1:0] kind;
        r = $urandom_range(0, 99);
        kind = (r < 40) ? gpb_pkg::KIND_BOX : (r < 70) ? gpb_pkg::KIND_GLUE :
               (r < 85) ? gpb_pkg::KIND_OTHER : gpb_pkg::KIND_ABSENT;
        return mk(kind, span_value(step_unit), span_value(step_unit), last_it);
    endfunction

    task automatic send_item(input gpb_pkg::t_item it);
        int gap;
        if (!quiet && $urandom_range(0, 99) < 20) begin
            gap = pick_gap();
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    // drain all pages, then let the back end settle before touching the target
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_target(input logic [gpb_pkg::TARGET_W-1:0] value);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        cfg_data <= $urandom;
        @(negedge i_clk);
        settings_used++;
    endtask

    // receiver: random stalls, plus one long hold-off when asked
    initial begin
        int stall_left;
        stall_left = 0;
        out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_OFF_CYCLES - 1;
                out_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < 15) begin
                stall_left = pick_gap() - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int                           phase;
        int                           len;
        int                           chunk;
        int                           r;
        int unsigned                  step_unit;
        logic [gpb_pkg::TARGET_W-1:0] tgt;

        i_rst_n    = 1'b0;
        cfg_we     = 1'b0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        in_item    = '0;
        quiet      = 1'b0;
        hold_req   = 1'b0;
        items_sent = 0;
        settings_used = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed list at a ten-unit target
        write_target(gpb_pkg::TARGET_W'(10 * U));
        send_item(mk(gpb_pkg::KIND_BOX, 3 * U, 1 * U, 1'b0));
        send_item(mk(gpb_pkg::KIND_GLUE, 3 * U, 0, 1'b0));
        send_item(mk(gpb_pkg::KIND_OTHER, 0, 0, 1'b0));
        send_item(mk(gpb_pkg::KIND_ABSENT, 0, 0, 1'b0));
        send_item(mk(gpb_pkg::KIND_BOX, 2 * U, 1 * U, 1'b0));      // lands exactly on target
        send_item(mk(gpb_pkg::KIND_GLUE, 1, 0, 1'b0));             // break with zero gap
        send_item(mk(gpb_pkg::KIND_BOX, -2 * U, 9 * U, 1'b0));
        send_item(mk(gpb_pkg::KIND_GLUE, 5 * U / 2, 0, 1'b0));
        send_item(mk(gpb_pkg::KIND_BOX, 1 * U, 0, 1'b1));          // break and final page
        send_item(mk(gpb_pkg::KIND_BOX, S32_MAX, S32_MAX, 1'b0));  // saturate high
        send_item(mk(gpb_pkg::KIND_GLUE, 1 * U, 0, 1'b0));         // negative gap, clipped
        send_item(mk(gpb_pkg::KIND_BOX, S32_MIN, S32_MIN, 1'b0));  // saturate low
        send_item(mk(gpb_pkg::KIND_GLUE, -1, 0, 1'b0));
        send_item(mk(gpb_pkg::KIND_GLUE, S32_MAX, 0, 1'b0));
        send_item(mk(gpb_pkg::KIND_GLUE, 12 * U, 0, 1'b0));
        send_item(mk(gpb_pkg::KIND_OTHER, 0, 0, 1'b1));
        send_item(mk(gpb_pkg::KIND_ABSENT, 0, 0, 1'b1));           // absent slot closes the run
        send_item(mk(gpb_pkg::KIND_ABSENT, 0, 0, 1'b0));
        send_item(mk(gpb_pkg::KIND_GLUE, 20 * U, 0, 1'b0));        // page of one absent slot
        send_item(mk(gpb_pkg::KIND_GLUE, -14 * U, 0, 1'b0));
        send_item(mk(gpb_pkg::KIND_GLUE, 5 * U, 0, 1'b0));         // gap of four units
        send_item(mk(gpb_pkg::KIND_GLUE, 1, 0, 1'b0));
        send_item(mk(gpb_pkg::KIND_GLUE, 5 * U, 0, 1'b0));         // gap just under five units
        send_item(mk(gpb_pkg::KIND_GLUE, 6 * U, 0, 1'b1));         // gap of exactly five units

        // random lists, mostly well formed, under changing targets
        phase = 0;
        chunk = 0;
        while (chunk < 1900) begin
            if (phase == 0) begin
                tgt = '0;
            end else if (phase == 1) begin
                tgt = {gpb_pkg::TARGET_W{1'b1}};
            end else begin
                r = $urandom_range(0, 3);
                if (r == 0) begin
                    tgt = gpb_pkg::TARGET_W'($urandom_range(1, 20 * U));
                end else if (r == 1) begin
                    tgt = gpb_pkg::TARGET_W'($urandom_range(20 * U, 2000 * U));
                end else begin
                    tgt = gpb_pkg::TARGET_W'($urandom);
                end
            end
            write_target(tgt);
            step_unit = tgt >> 2;
            if (step_unit < 2 * U) begin
                step_unit = 2 * U;
            end
            quiet = ($urandom_range(0, 3) == 0);
            if (phase == 2) begin
                hold_req = 1'b1;
            end
            len = $urandom_range(100, 200);
            for (int n = 0; n < len; ) begin
                if ($urandom_range(0, 99) < 85) begin
                    r = $urandom_range(1, 24);
                    for (int k = 0; k < r; k++) begin
                        send_item(random_item(step_unit, k == r - 1));
                    end
                end else begin
                    r = $urandom_range(1, 8);
                    for (int k = 0; k < r; k++) begin
                        send_item(random_item(step_unit, $urandom_range(0, 9) == 0));
                    end
                end
                n += r;
                chunk += r;
            end
            phase++;
        end

        wait_idle();
        repeat (20) @(negedge i_clk);
        $display("Run covered %0d list items over %0d target settings, with random gaps,",
                 items_sent, settings_used);
        $display("output stalls and a long hold-off; %0d page words compared, %0d mismatches.",
                 pages_checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
